/* rtl/stree_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stree_pkg
// Field widths, operation codes and status codes shared by the range-sum
// segment tree block.
// ----------------------------------------------------------------------------
package stree_pkg;

    localparam int OPCODE_W = 1;
    localparam int INDEX_W  = 10;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 11;

    // Element count after reset, clipped to the configured maximum.
    localparam int COUNT_RESET = 1024;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET   = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

endpackage

/* rtl/stree_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stree_ram
// Generic synchronous RAM: one write port and two read ports, each read
// registered. A read of an entry that is written
// in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module stree_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2047
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    output logic [WIDTH-1:0]         ra_data,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

/* rtl/segment_tree_range_sum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_tree_range_sum
// Binary segment tree of wrapped 32-bit sums with point update and inclusive
// range query, held in one node RAM.
// ----------------------------------------------------------------------------
// Usage
//   An item is taken at a rising edge with start high and busy low. Its one
//   result appears on range_sum and status for a single cycle with done high;
//   the receiver has no way to hold it off. busy is low in the cycle in which
//   done is high, so the next item may be started in that cycle.
//   A set walks down to the leaf, forms the difference between the new and
//   the old leaf value, and then adds it to each node on the path, one RAM
//   read and one write a cycle.
//   A query walks the prefix paths to range_last and to range_first-1 side by
//   side on the two read ports and subtracts the two prefix sums. An item
//   with a bad index gives its error result in the next cycle.
//   After reset, and after every write of element_count, the node RAM is
//   cleared one entry a cycle, all 2*P-1 entries with P the power of two at
//   or above MAX_ELEMENTS (2047 by default); busy stays high meanwhile.
// ----------------------------------------------------------------------------
module segment_tree_range_sum #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                element_count_we,
    input  logic [stree_pkg::COUNT_W-1:0]       element_count_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [stree_pkg::OPCODE_W-1:0]      opcode,
    input  logic [stree_pkg::INDEX_W-1:0]       elem_index,
    input  logic signed [stree_pkg::VALUE_W-1:0] elem_value,
    input  logic [stree_pkg::INDEX_W-1:0]       range_first,
    input  logic [stree_pkg::INDEX_W-1:0]       range_last,
    output logic                                done,
    output logic signed [stree_pkg::VALUE_W-1:0] range_sum,
    output logic                                status
);

    import stree_pkg::*;

    localparam int IW     = $clog2(MAX_ELEMENTS);
    localparam int CW     = $clog2(MAX_ELEMENTS + 1);
    localparam int P      = 1 << IW;
    localparam int NODES  = 2 * P - 1;
    localparam int AW     = $clog2(NODES);
    localparam int LEVELS = IW + 1;
    localparam int LW     = $clog2(LEVELS + 1);
    localparam int LIW    = $clog2(LEVELS);
    localparam int RESET_COUNT =
        (COUNT_RESET < MAX_ELEMENTS) ? COUNT_RESET : MAX_ELEMENTS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SET_DOWN,
        S_SET_DELTA,
        S_SET_UP,
        S_QUERY,
        S_Q_OUT
    } state_t;

    // Control and output registers.
    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [LW-1:0]        lvl_reg, lvl_next;
    logic [LW-1:0]        rp_reg, rp_next;
    logic                 fin_a_reg, fin_a_next;
    logic                 fin_b_reg, fin_b_next;
    logic                 pend_a_reg, pend_a_next;
    logic                 pend_b_reg, pend_b_next;
    logic                 done_reg, done_next;
    logic [VALUE_W-1:0]   sum_reg, sum_next;
    logic                 status_reg, status_next;

    // Datapath registers.
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [IW-1:0]        tgt_a_reg, tgt_a_next;
    logic [IW-1:0]        tgt_b_reg, tgt_b_next;
    logic [IW-1:0]        lo_a_reg, lo_a_next, hi_a_reg, hi_a_next;
    logic [IW-1:0]        lo_b_reg, lo_b_next, hi_b_reg, hi_b_next;
    logic [AW-1:0]        p_a_reg, p_a_next, p_b_reg, p_b_next;
    logic [VALUE_W-1:0]   acc_a_reg, acc_a_next, acc_b_reg, acc_b_next;
    logic [AW-1:0]        wa_reg, wa_next;
    logic [VALUE_W-1:0]   delta_reg, delta_next;
    logic [AW-1:0]        path_addr_reg [LEVELS];
    logic [AW-1:0]        path_addr_next [LEVELS];

    // Node RAM ports.
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [VALUE_W-1:0]   mem_wdata;
    logic [AW-1:0]        mem_ra_addr, mem_rb_addr;
    logic [VALUE_W-1:0]   mem_ra_data, mem_rb_data;

    // Split points and child addresses of the two walkers.
    logic [IW-1:0]        mid_a, mid_b;
    logic [AW-1:0]        pl_a, pr_a, pl_b, pr_b;
    logic [CW-1:0]        cnt_wr;

    stree_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (NODES)
    ) u_node_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .ra_addr (mem_ra_addr),
        .ra_data (mem_ra_data),
        .rb_addr (mem_rb_addr),
        .rb_data (mem_rb_data)
    );

    assign mid_a = IW'(({1'b0, lo_a_reg} + {1'b0, hi_a_reg}) >> 1);
    assign mid_b = IW'(({1'b0, lo_b_reg} + {1'b0, hi_b_reg}) >> 1);
    assign pl_a  = AW'({p_a_reg, 1'b1});
    assign pr_a  = AW'({p_a_reg, 1'b0} + (AW + 1)'(2));
    assign pl_b  = AW'({p_b_reg, 1'b1});
    assign pr_b  = AW'({p_b_reg, 1'b0} + (AW + 1)'(2));

    always_comb
    begin
        if (element_count_wdata == '0)
        begin
            cnt_wr = CW'(1);
        end
        else if (32'(element_count_wdata) > 32'(MAX_ELEMENTS))
        begin
            cnt_wr = CW'(MAX_ELEMENTS);
        end
        else
        begin
            cnt_wr = CW'(element_count_wdata);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        lvl_next       = lvl_reg;
        rp_next        = rp_reg;
        fin_a_next     = fin_a_reg;
        fin_b_next     = fin_b_reg;
        pend_a_next    = 1'b0;
        pend_b_next    = 1'b0;
        done_next      = 1'b0;
        sum_next       = sum_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        tgt_a_next     = tgt_a_reg;
        tgt_b_next     = tgt_b_reg;
        lo_a_next      = lo_a_reg;
        hi_a_next      = hi_a_reg;
        lo_b_next      = lo_b_reg;
        hi_b_next      = hi_b_reg;
        p_a_next       = p_a_reg;
        p_b_next       = p_b_reg;
        acc_a_next     = acc_a_reg;
        acc_b_next     = acc_b_reg;
        wa_next        = wa_reg;
        delta_next     = delta_reg;
        path_addr_next = path_addr_reg;
        mem_we         = 1'b0;
        mem_waddr      = wa_reg;
        mem_wdata      = '0;
        mem_ra_addr    = p_a_reg;
        mem_rb_addr    = p_b_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                if (clr_reg == AW'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    value_next  = elem_value;
                    lo_a_next   = '0;
                    hi_a_next   = IW'(cnt_reg - CW'(1));
                    p_a_next    = '0;
                    lo_b_next   = '0;
                    hi_b_next   = IW'(cnt_reg - CW'(1));
                    p_b_next    = '0;
                    acc_a_next  = '0;
                    acc_b_next  = '0;
                    lvl_next    = '0;
                    status_next = STATUS_OK;
                    sum_next    = '0;
                    if (opcode == OP_SET)
                    begin
                        if (32'(elem_index) >= 32'(cnt_reg))
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            tgt_a_next = IW'(elem_index);
                            state_next = S_SET_DOWN;
                        end
                    end
                    else
                    begin
                        if (range_first > range_last ||
                            32'(range_last) >= 32'(cnt_reg))
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_RANGE;
                        end
                        else
                        begin
                            // The lower walker finds the prefix sum just below
                            // range_first; none is needed when it is zero.
                            tgt_a_next = IW'(range_last);
                            tgt_b_next = IW'(range_first) - IW'(1);
                            fin_a_next = 1'b0;
                            fin_b_next = (range_first == '0);
                            state_next = S_QUERY;
                        end
                    end
                end
            end

            S_SET_DOWN:
            begin
                path_addr_next[lvl_reg[LIW-1:0]] = p_a_reg;
                lvl_next    = lvl_reg + LW'(1);
                mem_ra_addr = p_a_reg;
                if (lo_a_reg == hi_a_reg)
                begin
                    state_next = S_SET_DELTA;
                end
                else if (tgt_a_reg <= mid_a)
                begin
                    hi_a_next = mid_a;
                    p_a_next  = pl_a;
                end
                else
                begin
                    lo_a_next = mid_a + IW'(1);
                    p_a_next  = pr_a;
                end
            end

            S_SET_DELTA:
            begin
                // Every node on the path grows by the change of the leaf.
                delta_next  = value_reg - mem_ra_data;
                mem_ra_addr = path_addr_reg[0];
                wa_next     = path_addr_reg[0];
                rp_next     = LW'(1);
                state_next  = S_SET_UP;
            end

            S_SET_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = wa_reg;
                mem_wdata = mem_ra_data + delta_reg;
                if (rp_reg == lvl_reg)
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    sum_next    = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_ra_addr = path_addr_reg[rp_reg[LIW-1:0]];
                    wa_next     = path_addr_reg[rp_reg[LIW-1:0]];
                    rp_next     = rp_reg + LW'(1);
                end
            end

            S_QUERY:
            begin
                if (pend_a_reg)
                begin
                    acc_a_next = acc_a_reg + mem_ra_data;
                end
                if (pend_b_reg)
                begin
                    acc_b_next = acc_b_reg + mem_rb_data;
                end

                // A prefix walk takes a whole node when the target is its
                // right end, and the left child whenever it turns right.
                if (!fin_a_reg)
                begin
                    if (tgt_a_reg == hi_a_reg)
                    begin
                        mem_ra_addr = p_a_reg;
                        pend_a_next = 1'b1;
                        fin_a_next  = 1'b1;
                    end
                    else if (tgt_a_reg <= mid_a)
                    begin
                        hi_a_next = mid_a;
                        p_a_next  = pl_a;
                    end
                    else
                    begin
                        mem_ra_addr = pl_a;
                        pend_a_next = 1'b1;
                        lo_a_next   = mid_a + IW'(1);
                        p_a_next    = pr_a;
                    end
                end

                if (!fin_b_reg)
                begin
                    if (tgt_b_reg == hi_b_reg)
                    begin
                        mem_rb_addr = p_b_reg;
                        pend_b_next = 1'b1;
                        fin_b_next  = 1'b1;
                    end
                    else if (tgt_b_reg <= mid_b)
                    begin
                        hi_b_next = mid_b;
                        p_b_next  = pl_b;
                    end
                    else
                    begin
                        mem_rb_addr = pl_b;
                        pend_b_next = 1'b1;
                        lo_b_next   = mid_b + IW'(1);
                        p_b_next    = pr_b;
                    end
                end

                if (fin_a_reg && fin_b_reg)
                begin
                    state_next = S_Q_OUT;
                end
            end

            S_Q_OUT:
            begin
                done_next   = 1'b1;
                status_next = STATUS_OK;
                sum_next    = acc_a_reg - acc_b_reg;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase

        // A new element count changes the tree shape, so the tree is cleared.
        if (element_count_we)
        begin
            cnt_next   = cnt_wr;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cnt_reg    <= CW'(RESET_COUNT);
            clr_reg    <= '0;
            lvl_reg    <= '0;
            rp_reg     <= '0;
            fin_a_reg  <= 1'b1;
            fin_b_reg  <= 1'b1;
            pend_a_reg <= 1'b0;
            pend_b_reg <= 1'b0;
            done_reg   <= 1'b0;
            sum_reg    <= '0;
            status_reg <= STATUS_OK;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            clr_reg    <= clr_next;
            lvl_reg    <= lvl_next;
            rp_reg     <= rp_next;
            fin_a_reg  <= fin_a_next;
            fin_b_reg  <= fin_b_next;
            pend_a_reg <= pend_a_next;
            pend_b_reg <= pend_b_next;
            done_reg   <= done_next;
            sum_reg    <= sum_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        tgt_a_reg     <= tgt_a_next;
        tgt_b_reg     <= tgt_b_next;
        lo_a_reg      <= lo_a_next;
        hi_a_reg      <= hi_a_next;
        lo_b_reg      <= lo_b_next;
        hi_b_reg      <= hi_b_next;
        p_a_reg       <= p_a_next;
        p_b_reg       <= p_b_next;
        acc_a_reg     <= acc_a_next;
        acc_b_reg     <= acc_b_next;
        wa_reg        <= wa_next;
        delta_reg     <= delta_next;
        path_addr_reg <= path_addr_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign range_sum = sum_reg;
    assign status    = status_reg;

    // An item that failed its bounds check never carries a sum.
    a_error_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_RANGE) |-> (range_sum == '0))
        else $error("error result with a non-zero sum");

    // The downward walk of a set never records more nodes than the tree has levels.
    a_path_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SET_DOWN) |-> (lvl_reg < LW'(LEVELS)))
        else $error("set path deeper than the tree");

    // Walker a stays inside the node RAM.
    a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SET_DOWN || state_reg == S_QUERY) |-> (p_a_reg < AW'(NODES)))
        else $error("node address beyond the tree");

endmodule
